// ===== rtl/lds_pkg.sv =====
// Shared constants, types and helpers of the line directive stripper.
package lds_pkg;

	localparam int PREFIX_DEPTH = 32;
	localparam int PATH_DEPTH   = 256;
	localparam int LINE_WIDTH   = 24;

	localparam int HCW = $clog2(PREFIX_DEPTH + 1);
	localparam int HAW = $clog2(PREFIX_DEPTH);
	localparam int PCW = $clog2(PATH_DEPTH + 1);
	localparam int PAW = $clog2(PATH_DEPTH);

	localparam logic [LINE_WIDTH-1:0] LINE_MAX = {LINE_WIDTH{1'b1}};
	localparam logic [LINE_WIDTH-1:0] LINE_ONE = LINE_WIDTH'(1);

	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_PATH = 2'd1;
	localparam logic [1:0] KIND_REC  = 2'd2;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_L     = 8'h6c;

	typedef enum logic [3:0] {
		PH_START,
		PH_TEXT,
		PH_HASH,
		PH_KEYWORD,
		PH_SPACE2,
		PH_DIGITS,
		PH_AFTER_NUM,
		PH_PATH,
		PH_TAIL
	} phase_t;

	typedef struct packed {
		logic                  rec;
		logic [LINE_WIDTH-1:0] al;
		logic [LINE_WIDTH-1:0] ll;
		logic                  due;
		logic                  inp;
		logic                  tr;
		logic [HCW-1:0]        nrep;
		logic                  cur_en;
		logic                  cur_path;
		logic                  cur_first;
		logic [7:0]            cur_byte;
	} cmd_t;

	typedef struct packed {
		logic           we;
		logic [HAW-1:0] addr;
		logic [7:0]     data;
	} hp_wr_t;

	function automatic logic is_blank(input logic [7:0] b);
		return b inside {8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d};
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] i);
		case (i)
			3'd0: kw_char = 8'h6c;
			3'd1: kw_char = 8'h69;
			3'd2: kw_char = 8'h6e;
			3'd3: kw_char = 8'h65;
			default: kw_char = 8'h00;
		endcase
	endfunction

	function automatic logic [LINE_WIDTH-1:0] sat_inc(input logic [LINE_WIDTH-1:0] v);
		return (v == LINE_MAX) ? v : v + LINE_ONE;
	endfunction

endpackage

// ===== rtl/lds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lds_cmd_fifo.sv =====
// Two-entry command queue between the parser and the output sequencer.
module lds_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lds_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          head_valid,
	output lds_pkg::cmd_t head_cmd,
	input  logic          pop
);
	import lds_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_cmd   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/lds_front.sv =====
// Parser: accepts items, tracks lines and path, issues output commands.
module lds_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           req_type,
	input  logic [7:0]     byte_value,
	output logic           push,
	output lds_pkg::cmd_t  cmd,
	input  logic           fifo_full,
	input  logic           rep_done,
	output lds_pkg::hp_wr_t hp_wr
);
	import lds_pkg::*;

	phase_t                phase_q, phase_d;
	logic [2:0]            kw_q, kw_d;
	logic [HCW-1:0]        held_q, held_d;
	logic [LINE_WIDTH-1:0] num_q, num_d, act_q, act_d, log_q, log_d;
	logic [PCW-1:0]        plen_q, plen_d, ci_q, ci_d, ci_n;
	logic                  differs_q, differs_d, logged_q, logged_d;
	logic                  inp_q, inp_d, cut_q, cut_d;
	logic                  pend_q;
	logic                  acc_in;
	logic                  pw_we;
	logic [PAW-1:0]        pw_addr;
	logic [7:0]            p_rdata;

	assign in_ready = !fifo_full && !pend_q;
	assign acc_in   = in_valid && in_ready;
	assign ci_n     = acc_in ? ci_d : ci_q;

	lds_ram #(.WIDTH(8), .DEPTH(PATH_DEPTH)) u_path_ram (
		.clk   (clk),
		.we    (pw_we),
		.waddr (pw_addr),
		.wdata (byte_value),
		.raddr (ci_n[PAW-1:0]),
		.rdata (p_rdata)
	);

	always_comb begin
		logic [7:0]            b;
		logic                  nl;
		logic                  a_hold, a_rej, rej_cur, a_acc;
		logic [LINE_WIDTH+3:0] t;
		logic [LINE_WIDTH-1:0] ll_rec;
		b = byte_value;
		nl = (b == CH_NL);
		a_hold = 1'b0;
		a_rej = 1'b0;
		rej_cur = 1'b0;
		a_acc = 1'b0;
		t = '0;
		ll_rec = '0;
		phase_d = phase_q;
		kw_d = kw_q;
		held_d = held_q;
		num_d = num_q;
		act_d = act_q;
		log_d = log_q;
		plen_d = plen_q;
		ci_d = ci_q;
		differs_d = differs_q;
		logged_d = logged_q;
		inp_d = inp_q;
		cut_d = cut_q;
		cmd = '0;
		cmd.cur_byte = b;
		hp_wr = '0;
		hp_wr.data = b;
		pw_we = 1'b0;
		pw_addr = ci_q[PAW-1:0];
		if (!req_type) begin
			case (phase_q)
				PH_START: begin
					if (b == CH_HASH) begin
						hp_wr.we = 1'b1;
						held_d = HCW'(1);
						phase_d = PH_HASH;
					end else begin
						a_rej = 1'b1;
						rej_cur = 1'b1;
					end
				end
				PH_TEXT: begin
					cmd.cur_en = 1'b1;
					if (nl) begin
						act_d = sat_inc(act_q);
						log_d = sat_inc(log_q);
						phase_d = PH_START;
					end
				end
				PH_HASH, PH_SPACE2: begin
					if (nl) begin
						a_rej = 1'b1;
						rej_cur = 1'b1;
					end else if (is_blank(b)) begin
						a_hold = 1'b1;
					end else if (phase_q == PH_HASH && b == CH_L) begin
						kw_d = 3'd1;
						phase_d = PH_KEYWORD;
						a_hold = 1'b1;
					end else if (is_digit(b)) begin
						num_d = LINE_WIDTH'(b[3:0]);
						phase_d = PH_DIGITS;
						a_hold = 1'b1;
					end else begin
						a_rej = 1'b1;
						rej_cur = 1'b1;
					end
				end
				PH_KEYWORD: begin
					if (!nl && kw_q < 3'd4 && b == kw_char(kw_q)) begin
						kw_d = kw_q + 3'd1;
						if (kw_d >= 3'd4) begin
							phase_d = PH_SPACE2;
						end
						a_hold = 1'b1;
					end else begin
						a_rej = 1'b1;
						rej_cur = 1'b1;
					end
				end
				PH_DIGITS, PH_AFTER_NUM: begin
					if (phase_q == PH_DIGITS && is_digit(b)) begin
						t = {4'b0, num_q} * (LINE_WIDTH + 4)'(10) + (LINE_WIDTH + 4)'(b[3:0]);
						num_d = (t > {4'b0, LINE_MAX}) ? LINE_MAX : t[LINE_WIDTH-1:0];
						a_hold = 1'b1;
					end else begin
						if (phase_q == PH_DIGITS) begin
							log_d = num_q;
						end
						if (nl) begin
							a_acc = 1'b1;
						end else if (is_blank(b)) begin
							phase_d = PH_AFTER_NUM;
							a_hold = 1'b1;
						end else if (b == CH_QUOTE) begin
							held_d = '0;
							differs_d = inp_q || cut_q;
							inp_d = 1'b0;
							cut_d = 1'b0;
							ci_d = '0;
							phase_d = PH_PATH;
						end else begin
							a_rej = 1'b1;
							rej_cur = 1'b1;
						end
					end
				end
				PH_PATH: begin
					if (b == CH_QUOTE) begin
						if (ci_q != plen_q || cut_q) begin
							differs_d = 1'b1;
						end
						plen_d = ci_q;
						phase_d = PH_TAIL;
					end else begin
						if (ci_q < PCW'(PATH_DEPTH)) begin
							if (ci_q >= plen_q || p_rdata != b) begin
								differs_d = 1'b1;
							end
							pw_we = 1'b1;
							ci_d = ci_q + PCW'(1);
							cmd.cur_en = 1'b1;
							cmd.cur_path = 1'b1;
						end else begin
							cut_d = 1'b1;
						end
						if (nl) begin
							if (ci_d != plen_q || cut_d) begin
								differs_d = 1'b1;
							end
							plen_d = ci_d;
							cmd.cur_first = 1'b1;
							a_acc = 1'b1;
						end
					end
				end
				default: begin
					if (nl) begin
						a_acc = 1'b1;
					end
				end
			endcase
		end else begin
			case (phase_q)
				PH_START, PH_HASH, PH_KEYWORD, PH_SPACE2: a_rej = 1'b1;
				PH_DIGITS: begin
					log_d = num_q;
					a_acc = 1'b1;
				end
				PH_AFTER_NUM, PH_TAIL: a_acc = 1'b1;
				PH_PATH: begin
					if (ci_q != plen_q || cut_q) begin
						differs_d = 1'b1;
					end
					plen_d = ci_q;
					a_acc = 1'b1;
				end
				default: ;
			endcase
		end

		if (a_hold) begin
			if (held_d < HCW'(PREFIX_DEPTH)) begin
				hp_wr.we = 1'b1;
				hp_wr.addr = held_d[HAW-1:0];
				held_d = held_d + HCW'(1);
			end else begin
				if (phase_d == PH_DIGITS) begin
					log_d = num_d;
				end
				a_rej = 1'b1;
				rej_cur = 1'b1;
			end
		end
		if (a_rej) begin
			ll_rec = log_d;
			if (!logged_d) begin
				cmd.rec = 1'b1;
				cmd.due = 1'b1;
			end
			cmd.nrep = held_d;
			held_d = '0;
			phase_d = PH_TEXT;
			if (rej_cur) begin
				cmd.cur_en = 1'b1;
				if (nl) begin
					act_d = sat_inc(act_d);
					log_d = sat_inc(log_d);
					phase_d = PH_START;
				end
			end
		end
		if (a_acc) begin
			ll_rec = log_d;
			held_d = '0;
			cmd.rec = 1'b1;
			cmd.due = !logged_d || differs_d;
			phase_d = PH_START;
		end
		if (cmd.rec) begin
			cmd.al = act_q;
			cmd.ll = ll_rec;
			cmd.inp = inp_d;
			cmd.tr = cut_d;
			logged_d = 1'b1;
			differs_d = 1'b0;
		end
		if (req_type) begin
			phase_d = PH_START;
			kw_d = '0;
			held_d = '0;
			num_d = '0;
			act_d = LINE_ONE;
			log_d = LINE_ONE;
			plen_d = '0;
			ci_d = '0;
			differs_d = 1'b0;
			logged_d = 1'b0;
			inp_d = 1'b1;
			cut_d = 1'b0;
		end
		if (!acc_in) begin
			hp_wr.we = 1'b0;
			pw_we = 1'b0;
		end
	end

	assign push = acc_in && (cmd.rec || cmd.nrep != '0 || cmd.cur_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			kw_q      <= '0;
			held_q    <= '0;
			num_q     <= '0;
			act_q     <= LINE_ONE;
			log_q     <= LINE_ONE;
			plen_q    <= '0;
			ci_q      <= '0;
			differs_q <= 1'b0;
			logged_q  <= 1'b0;
			inp_q     <= 1'b1;
			cut_q     <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (acc_in) begin
				phase_q   <= phase_d;
				kw_q      <= kw_d;
				held_q    <= held_d;
				num_q     <= num_d;
				act_q     <= act_d;
				log_q     <= log_d;
				plen_q    <= plen_d;
				ci_q      <= ci_d;
				differs_q <= differs_d;
				logged_q  <= logged_d;
				inp_q     <= inp_d;
				cut_q     <= cut_d;
			end
			if (push && cmd.nrep != '0) begin
				pend_q <= 1'b1;
			end else if (rep_done) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/lds_back.sv =====
// Output sequencer: expands commands into records, replayed and passed bytes.
module lds_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  lds_pkg::cmd_t                   head_cmd,
	output logic                            pop,
	output logic [lds_pkg::HAW-1:0]         hp_raddr,
	input  logic [7:0]                      hp_rdata,
	output logic                            rep_done,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      item_kind,
	output logic [7:0]                      out_byte,
	output logic [lds_pkg::LINE_WIDTH-1:0]  actual_line,
	output logic [lds_pkg::LINE_WIDTH-1:0]  logical_line,
	output logic                            file_record_due,
	output logic                            path_from_input_name,
	output logic                            path_truncated,
	output logic                            last_of_run
);
	import lds_pkg::*;

	cmd_t           cmd_q;
	logic           busy_q, rec_left_q, cur_left_q, rd_ok_q;
	logic [HCW-1:0] rep_idx_q;
	logic           slot, emit, e_rec, e_rep, e_cur, e_last;
	logic           rec_n, cur_n, remain;
	logic [HCW-1:0] rep_n;

	assign slot     = !out_valid || out_ready;
	assign hp_raddr = rep_idx_q[HAW-1:0];

	always_comb begin
		e_rec = 1'b0;
		e_rep = 1'b0;
		e_cur = 1'b0;
		e_last = 1'b0;
		rec_n = rec_left_q;
		cur_n = cur_left_q;
		rep_n = rep_idx_q;
		rep_done = 1'b0;
		if (busy_q && slot) begin
			if (cmd_q.cur_first && cur_left_q) begin
				e_cur = 1'b1;
				cur_n = 1'b0;
			end else if (rec_left_q) begin
				e_rec = 1'b1;
				rec_n = 1'b0;
			end else if (rep_idx_q < cmd_q.nrep) begin
				if (rd_ok_q) begin
					e_rep = 1'b1;
					rep_n = rep_idx_q + HCW'(1);
					rep_done = (rep_n == cmd_q.nrep);
				end
			end else if (cur_left_q) begin
				e_cur = 1'b1;
				cur_n = 1'b0;
			end
		end
		emit = e_rec || e_rep || e_cur;
		remain = rec_n || cur_n || (rep_n < cmd_q.nrep);
		e_last = !remain;
		pop = head_valid && (!busy_q || !remain);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rec_left_q <= 1'b0;
			cur_left_q <= 1'b0;
			rd_ok_q    <= 1'b0;
			rep_idx_q  <= '0;
			out_valid  <= 1'b0;
		end else begin
			rd_ok_q <= !e_rep && !pop;
			if (pop) begin
				busy_q     <= 1'b1;
				rec_left_q <= head_cmd.rec;
				cur_left_q <= head_cmd.cur_en;
				rep_idx_q  <= '0;
			end else begin
				busy_q     <= busy_q && remain;
				rec_left_q <= rec_n;
				cur_left_q <= cur_n;
				rep_idx_q  <= rep_n;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
		if (emit) begin
			last_of_run          <= e_last;
			item_kind            <= e_rec ? KIND_REC :
			                        (e_cur && cmd_q.cur_path) ? KIND_PATH : KIND_TEXT;
			out_byte             <= e_rec ? 8'h00 : (e_rep ? hp_rdata : cmd_q.cur_byte);
			actual_line          <= e_rec ? cmd_q.al : '0;
			logical_line         <= e_rec ? cmd_q.ll : '0;
			file_record_due      <= e_rec && cmd_q.due;
			path_from_input_name <= e_rec && cmd_q.inp;
			path_truncated       <= e_rec && cmd_q.tr;
		end
	end

endmodule

// ===== rtl/line_directive_stripper_core.sv =====
// Top level of the line directive stripper: parser, command queue, sequencer.
//
// Channel | Handshake           | Payload
// input   | in_valid / in_ready | req_type, byte_value
// output  | out_valid/out_ready | item_kind, out_byte, actual_line, logical_line,
//         |                     | file_record_due, path_from_input_name,
//         |                     | path_truncated, last_of_run
//
// The parser takes one item per cycle while the two-entry command queue has room.
// A rejected directive replays its held prefix from the prefix RAM, one registered
// read per byte; the parser stalls until that replay is finished.
// Other items produce one output item per cycle once the output register drains.
// Reset clears all control state; prefix and path RAM contents need no clearing.
module line_directive_stripper_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [7:0]                     byte_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     item_kind,
	output logic [7:0]                     out_byte,
	output logic [lds_pkg::LINE_WIDTH-1:0] actual_line,
	output logic [lds_pkg::LINE_WIDTH-1:0] logical_line,
	output logic                           file_record_due,
	output logic                           path_from_input_name,
	output logic                           path_truncated,
	output logic                           last_of_run
);
	import lds_pkg::*;

	logic           push, full, head_valid, pop, rep_done;
	cmd_t           push_cmd, head_cmd;
	hp_wr_t         hp_wr;
	logic [HAW-1:0] hp_raddr;
	logic [7:0]     hp_rdata;

	lds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.byte_value (byte_value),
		.push       (push),
		.cmd        (push_cmd),
		.fifo_full  (full),
		.rep_done   (rep_done),
		.hp_wr      (hp_wr)
	);

	lds_ram #(.WIDTH(8), .DEPTH(PREFIX_DEPTH)) u_prefix_ram (
		.clk   (clk),
		.we    (hp_wr.we),
		.waddr (hp_wr.addr),
		.wdata (hp_wr.data),
		.raddr (hp_raddr),
		.rdata (hp_rdata)
	);

	lds_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	lds_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.head_valid           (head_valid),
		.head_cmd             (head_cmd),
		.pop                  (pop),
		.hp_raddr             (hp_raddr),
		.hp_rdata             (hp_rdata),
		.rep_done             (rep_done),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.item_kind            (item_kind),
		.out_byte             (out_byte),
		.actual_line          (actual_line),
		.logical_line         (logical_line),
		.file_record_due      (file_record_due),
		.path_from_input_name (path_from_input_name),
		.path_truncated       (path_truncated),
		.last_of_run          (last_of_run)
	);

endmodule
